// ===== rtl/core/astm_pkg.sv =====
// shared types, constants and sine table functions for the tone mixer
package astm_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned PHASE_STEP_W = 32;
  localparam int unsigned NOTE_LEN_W   = 16;
  localparam int unsigned ENV_W        = 17;
  localparam int unsigned STEP_W       = 16;
  localparam int unsigned SINE_MAG_W   = 15;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST  = 32'd101920264;
  localparam logic [NOTE_LEN_W-1:0]   NOTE_LENGTH_RST = 16'd5512;
  localparam int unsigned             ATTACK_RST_INT  = 119;
  localparam logic [ENV_W-1:0]        ATTACK_STEP_RST = ENV_W'(ATTACK_RST_INT);
  localparam logic [STEP_W-1:0]       DECAY_STEP_RST  = STEP_W'((3 * ATTACK_RST_INT) / 10);
  localparam logic [STEP_W-1:0]       RELEASE_STEP_RST = STEP_W'((7 * ATTACK_RST_INT) / 20);

  localparam logic [ENV_W-1:0] ENV_ONE     = 17'd65536;
  localparam logic [ENV_W-1:0] ENV_SUSTAIN = 17'd45875;

  localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_POS = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_NEG = -16'sd32767;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_NOTE_LENGTH = 2'd1,
    CFG_ATTACK_STEP = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEG_ATTACK,
    SEG_DECAY,
    SEG_SUSTAIN,
    SEG_RELEASE
  } seg_t;

  typedef struct packed {
    logic [ENV_W-1:0] env;
    logic             sine_neg;
    logic             note_end;
  } astm_ctl_t;

  // q30 sine by taylor series through the x^11 term
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    return sum;
  endfunction

  // quarter-wave entry k, sampled at the middle of its slot
  function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned idx_bits);
    longint unsigned kk;
    longint unsigned x;
    longint unsigned v;
    kk = longint'(k);
    x  = (HALF_PI_Q30 * (2 * kk + 1)) >> (idx_bits + 1);
    v  = (sin_q30(x) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/core/astm_sine_rom.sv =====
// quarter-wave sine rom with registered read
module astm_sine_rom
  import astm_pkg::*;
#(
  parameter int unsigned IDX_BITS = 10
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [IDX_BITS-1:0]   addr,
  output logic [SINE_MAG_W-1:0] mag
);

  localparam int unsigned DEPTH = 1 << IDX_BITS;

  logic [SINE_MAG_W-1:0] rom [DEPTH];
  logic [SINE_MAG_W-1:0] mag_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom[k] = sine_entry(k, IDX_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= rom[addr];
    end
  end

  assign mag = mag_r;

endmodule

// ===== rtl/core/astm_env_ctrl.sv =====
// note position, phase accumulator and envelope level tracking
module astm_env_ctrl
  import astm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_INDEX_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       restart,
  input  logic [PHASE_STEP_W-1:0]    phase_step,
  input  logic [NOTE_LEN_W-1:0]      note_length,
  input  logic [ENV_W-1:0]           attack_step,
  input  logic [STEP_W-1:0]          decay_step,
  input  logic [STEP_W-1:0]          release_step,
  output astm_ctl_t                  ctl,
  output logic [SINE_INDEX_BITS-1:0] rom_addr
);

  logic [NOTE_LEN_W-1:0] idx_r,   idx_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [ENV_W-1:0]      lvl_r,   lvl_nxt;

  logic [NOTE_LEN_W-1:0] idx_cur;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [ENV_W-1:0]      lvl_cur;
  logic [ENV_W-1:0]      env;
  logic [ENV_W-1:0]      env_clip;
  logic [ENV_W-1:0]      lvl_upd;
  logic [ENV_W:0]        attack_sum;
  logic [ENV_W:0]        decay_floor;
  logic [19:0]           idx_x10;
  logic [18:0]           idx_x5;
  logic [18:0]           len_x4;
  logic                  last;
  seg_t                  seg;
  logic [1:0]                 quad;
  logic [SINE_INDEX_BITS-1:0] slot;

  // restart takes effect before this sample
  assign idx_cur   = restart ? '0 : idx_r;
  assign phase_cur = restart ? '0 : phase_r;
  assign lvl_cur   = restart ? '0 : lvl_r;

  assign idx_x10 = ({4'b0, idx_cur} << 3) + ({4'b0, idx_cur} << 1);
  assign idx_x5  = ({3'b0, idx_cur} << 2) + {3'b0, idx_cur};
  assign len_x4  = {1'b0, note_length, 2'b00};

  always_comb begin
    if (idx_x10 < {4'b0, note_length}) begin
      seg = SEG_ATTACK;
    end else if (idx_x5 < {3'b0, note_length}) begin
      seg = SEG_DECAY;
    end else if (idx_x5 < len_x4) begin
      seg = SEG_SUSTAIN;
    end else begin
      seg = SEG_RELEASE;
    end
  end

  assign env_clip    = (lvl_cur > ENV_ONE) ? ENV_ONE : lvl_cur;
  assign attack_sum  = {1'b0, lvl_cur} + {1'b0, attack_step};
  assign decay_floor = {1'b0, ENV_SUSTAIN} + {2'b0, decay_step};

  always_comb begin
    case (seg)
      SEG_ATTACK: begin
        env     = lvl_cur;
        lvl_upd = (attack_sum > {1'b0, ENV_ONE}) ? ENV_ONE : attack_sum[ENV_W-1:0];
      end
      SEG_DECAY: begin
        env     = env_clip;
        lvl_upd = ({1'b0, env_clip} >= decay_floor) ? env_clip - {1'b0, decay_step}
                                                    : ENV_SUSTAIN;
      end
      SEG_SUSTAIN: begin
        env     = ENV_SUSTAIN;
        lvl_upd = ENV_SUSTAIN;
      end
      SEG_RELEASE: begin
        env     = env_clip;
        lvl_upd = (env_clip >= {1'b0, release_step}) ? env_clip - {1'b0, release_step}
                                                     : '0;
      end
      default: begin
        env     = '0;
        lvl_upd = '0;
      end
    endcase
  end

  assign last = ({1'b0, idx_cur} + 17'd1) >= {1'b0, note_length};

  // quadrant from the top phase bits, mirrored in odd quadrants
  assign quad     = phase_cur[PHASE_BITS-1 -: 2];
  assign slot     = phase_cur[PHASE_BITS-3 -: SINE_INDEX_BITS];
  assign rom_addr = quad[0] ? ~slot : slot;

  assign ctl.env      = env;
  assign ctl.sine_neg = quad[1];
  assign ctl.note_end = last;

  always_comb begin
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    lvl_nxt   = lvl_r;
    if (accept) begin
      if (last) begin
        idx_nxt   = '0;
        phase_nxt = '0;
        lvl_nxt   = '0;
      end else begin
        idx_nxt   = idx_cur + 16'd1;
        phase_nxt = phase_cur + PHASE_BITS'(phase_step);
        lvl_nxt   = lvl_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= '0;
      lvl_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

// ===== rtl/core/astm_mix.sv =====
// envelope multiply, then mix with the existing sample and saturate
module astm_mix
  import astm_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic [SINE_MAG_W-1:0]      sine_mag,
  input  logic                       sine_neg,
  input  logic [ENV_W-1:0]           env,
  input  logic signed [SAMPLE_W-1:0] existing,
  output logic signed [SAMPLE_W-1:0] mixed
);

  localparam int unsigned PROD_W = 34;
  localparam int unsigned Q_W    = PROD_W - ENV_W;

  logic signed [SAMPLE_W-1:0] sine_s;
  logic signed [PROD_W-1:0]   prod_r,  prod_nxt;
  logic signed [SAMPLE_W-1:0] exist_r;
  logic signed [SAMPLE_W-1:0] mixed_r, mixed_nxt;
  logic signed [PROD_W-1:0]   num;
  logic signed [Q_W-1:0]      quot;
  logic signed [Q_W-1:0]      quot_tz;
  logic                       round_up;

  assign sine_s   = sine_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  assign prod_nxt = PROD_W'(sine_s) * $signed(PROD_W'({1'b0, env}));

  // existing * 2^17 + product, divided by 2^17 toward zero
  assign num      = (PROD_W'(exist_r) <<< ENV_W) + prod_r;
  assign quot     = num[PROD_W-1:ENV_W];
  assign round_up = num[PROD_W-1] && (|num[ENV_W-1:0]);
  assign quot_tz  = quot + Q_W'(round_up);

  always_comb begin
    if (quot_tz > Q_W'(FULL_SCALE_POS)) begin
      mixed_nxt = FULL_SCALE_POS;
    end else if (quot_tz < Q_W'(FULL_SCALE_NEG)) begin
      mixed_nxt = FULL_SCALE_NEG;
    end else begin
      mixed_nxt = quot_tz[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      exist_r <= existing;
      mixed_r <= mixed_nxt;
    end
  end

  assign mixed = mixed_r;

endmodule

// ===== rtl/core/adsr_sine_tone_mixer_unit.sv =====
// top level of the enveloped sine tone mixer
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | in_existing_sample, in_restart
//   out     | output    | out_valid/out_stall| out_mixed_sample, out_note_end
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one transfer per cycle in each direction unless a finished result waits under out_stall
// the path from input to output runs through rom read, envelope multiply and saturating mix stages
// rst_n is synchronous: clears note index, phase, level and valids, reloads config
// the whole pipeline holds while a finished result waits under out_stall
// and accepts a new transfer as soon as the output slot is free
module adsr_sine_tone_mixer_unit
  import astm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_INDEX_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_existing_sample,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_mixed_sample,
  output logic                       out_note_end,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  // config registers
  logic [PHASE_STEP_W-1:0] phase_step_r;
  logic [NOTE_LEN_W-1:0]   note_length_r;
  logic [ENV_W-1:0]        attack_step_r;
  logic [STEP_W-1:0]       decay_step_r;
  logic [STEP_W-1:0]       release_step_r;

  // decay and release steps are derived when attack_step is written
  logic [ENV_W-1:0] wr_attack;
  logic [19:0]      atk_x3;
  logic [19:0]      atk_x7;
  logic [41:0]      decay_prod;
  logic [43:0]      release_prod;

  // pipeline control
  logic      adv;
  logic      accept;
  astm_ctl_t ctl;
  astm_ctl_t ctl1_r;
  logic      v1_r;
  logic      v2_r;
  logic      end2_r;
  logic      out_valid_r;
  logic      out_note_end_r;
  logic signed [SAMPLE_W-1:0] exist1_r;
  logic [SINE_INDEX_BITS-1:0] rom_addr;
  logic [SINE_MAG_W-1:0]      sine_mag;

  assign wr_attack = cfg_wdata[ENV_W-1:0];
  assign atk_x3    = ({3'b0, wr_attack} << 1) + {3'b0, wr_attack};
  assign atk_x7    = ({3'b0, wr_attack} << 3) - {3'b0, wr_attack};
  // floor(x/10) as x * ceil(2^22/10) >> 22, exact for x below 699050
  assign decay_prod   = 42'(atk_x3) * 42'd419431;
  // floor(x/20) as x * ceil(2^24/20) >> 24, exact for x below 2^22
  assign release_prod = 44'(atk_x7) * 44'd838861;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RST;
      note_length_r  <= NOTE_LENGTH_RST;
      attack_step_r  <= ATTACK_STEP_RST;
      decay_step_r   <= DECAY_STEP_RST;
      release_step_r <= RELEASE_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP: begin
          phase_step_r <= cfg_wdata[PHASE_STEP_W-1:0];
        end
        CFG_NOTE_LENGTH: begin
          note_length_r <= cfg_wdata[NOTE_LEN_W-1:0];
        end
        CFG_ATTACK_STEP: begin
          attack_step_r  <= wr_attack;
          decay_step_r   <= decay_prod[22 +: STEP_W];
          release_step_r <= release_prod[24 +: STEP_W];
        end
        default: begin
        end
      endcase
    end
  end

  // everything moves together unless a result sits unclaimed at the output
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  astm_env_ctrl #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_env_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .restart      (in_restart),
    .phase_step   (phase_step_r),
    .note_length  (note_length_r),
    .attack_step  (attack_step_r),
    .decay_step   (decay_step_r),
    .release_step (release_step_r),
    .ctl          (ctl),
    .rom_addr     (rom_addr)
  );

  astm_sine_rom #(
    .IDX_BITS (SINE_INDEX_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .en   (adv),
    .addr (rom_addr),
    .mag  (sine_mag)
  );

  // stage 1 payload, aligned with the rom output, and the note_end flag carried on to the output
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1_r   <= ctl;
      exist1_r <= in_existing_sample;
      end2_r   <= ctl1_r.note_end;
      out_note_end_r <= end2_r;
    end
  end

  // valid bits through the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  astm_mix u_mix (
    .clk      (clk),
    .en       (adv),
    .sine_mag (sine_mag),
    .sine_neg (ctl1_r.sine_neg),
    .env      (ctl1_r.env),
    .existing (exist1_r),
    .mixed    (out_mixed_sample)
  );

  assign out_valid    = out_valid_r;
  assign out_note_end = out_note_end_r;

endmodule
